>>> design/signed_int_to_radix_symbols_top_macros.svh
// Assertion helpers for the radix symbol converter.
// Simulation gets the checks; synthesis sees empty macros.
`ifndef SIGNED_INT_TO_RADIX_SYMBOLS_TOP_MACROS_SVH
`define SIGNED_INT_TO_RADIX_SYMBOLS_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define SIRS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled during reset
`define SIRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`else

`define SIRS_ASSERT_IMP(label, ante, cons)
`define SIRS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> design/sirs_pkg.sv
`default_nettype none

package sirs_pkg;

  // Data widths
  localparam int DATA_W     = 32;
  localparam int SYM_W      = 8;
  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Alphabet
  localparam int MAX_BASE   = 16;
  localparam int ALPHA_W    = MAX_BASE * SYM_W;

  // Digit store: one entry per bit of the magnitude at most
  localparam int MAX_DIGITS = DATA_W;
  localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
  localparam int DIG_CNT_W  = DIG_IDX_W + 1;

  // Divider: quotient bits resolved per cycle
  localparam int DIV_BITS   = 8;
  localparam int DIV_STEPS  = DATA_W / DIV_BITS;
  localparam int DIV_STEP_W = $clog2(DIV_STEPS);

  // Character codes
  localparam logic [SYM_W-1:0] SYM_MIN   = 8'd33;
  localparam logic [SYM_W-1:0] SYM_MAX   = 8'd126;
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  // Divider status back to the sequencer
  typedef struct packed {
    logic               done;
    logic [DATA_W-1:0]  quot;
    logic [DIGIT_W-1:0] rem;
  } div_res_t;

endpackage

`default_nettype wire

>>> design/sirs_div.sv
`default_nettype none

// Restoring divider by a radix of up to 16, DIV_BITS quotient bits a cycle.
// Dividend and quotient share one shift register.
module sirs_div import sirs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DATA_W-1:0]  dividend,
  input  logic [RADIX_W-1:0] divisor,
  output div_res_t           res
);

  logic [DATA_W-1:0]     acc;
  logic [DIGIT_W-1:0]    rem;
  logic [DIV_STEP_W-1:0] step;
  logic                  busy;
  logic                  done;

  logic [DATA_W-1:0]     acc_next;
  logic [DIGIT_W-1:0]    rem_next;

  // One slice of long division: shift in a bit, subtract when it fits
  always_comb begin
    logic [RADIX_W-1:0] trial;
    acc_next = acc;
    rem_next = rem;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial = {rem_next, acc_next[DATA_W-1]};
      if (trial >= divisor) begin
        rem_next = DIGIT_W'(trial - divisor);
        acc_next = {acc_next[DATA_W-2:0], 1'b1};
      end else begin
        rem_next = trial[DIGIT_W-1:0];
        acc_next = {acc_next[DATA_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc  <= dividend;
        rem  <= '0;
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        acc  <= acc_next;
        rem  <= rem_next;
        step <= step + DIV_STEP_W'(1);
        if (step == DIV_STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res = '{done: done, quot: acc, rem: rem};

endmodule

`default_nettype wire

>>> design/signed_int_to_radix_symbols_top.sv
// Converts each 32-bit signed value into characters of a programmable radix
// (2 to 16) with a user-supplied alphabet, one character per output item, most
// significant digit first, '-' ahead of negative values, last set on the final
// character. An alphabet that is too short or long, holds a symbol outside
// 33..126, holds '+' or '-', or repeats a symbol yields no output at all.
// Per value: the value is accepted, the alphabet is checked one symbol per
// cycle, the shared divider yields one digit per division pass, and then one
// character is loaded per cycle while the output is not stalled. The input is
// not ready until the last character has been loaded into the output register.
`default_nettype none
`include "signed_int_to_radix_symbols_top_macros.svh"

module signed_int_to_radix_symbols_top import sirs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [DATA_W-1:0] value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SYM_W-1:0]       symbol,
  output logic                   last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_EMIT
  } state_t;

  logic [RADIX_W-1:0]    base_length;
  logic [CFG_DATA_W-1:0] symbols_low;
  logic [CFG_DATA_W-1:0] symbols_high;

  state_t                state;
  logic [DATA_W-1:0]     mag;
  logic                  neg;
  logic [DIGIT_W-1:0]    idx;
  logic [DIG_CNT_W-1:0]  cnt;
  logic [DIGIT_W-1:0]    digits [MAX_DIGITS];

  logic [ALPHA_W-1:0]    alpha;
  logic [DATA_W-1:0]     value_u;
  logic                  len_ok;
  logic [SYM_W-1:0]      cur_sym;
  logic                  sym_bad;
  logic                  check_last;
  logic                  div_start;
  logic                  div_finish;
  logic [DATA_W-1:0]     div_dividend;
  div_res_t              div_res;
  logic                  slot_free;
  logic [DIG_CNT_W-1:0]  cnt_dec;
  logic [DIGIT_W-1:0]    emit_digit;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_length  <= '0;
      symbols_low  <= '0;
      symbols_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_LENGTH:  base_length  <= cfg_data[RADIX_W-1:0];
        REG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        REG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign alpha   = {symbols_high, symbols_low};
  assign value_u = value;
  assign len_ok  = (base_length >= RADIX_W'(2)) && (base_length <= RADIX_W'(MAX_BASE));

  // Alphabet check, one symbol per cycle against every later symbol in use
  always_comb begin
    cur_sym = alpha[{idx, 3'b000} +: SYM_W];
    sym_bad = (cur_sym < SYM_MIN) || (cur_sym > SYM_MAX) ||
              (cur_sym == SYM_PLUS) || (cur_sym == SYM_MINUS);
    for (int j = 0; j < MAX_BASE; j++) begin
      if ((RADIX_W'(j) > {1'b0, idx}) && (RADIX_W'(j) < base_length) &&
          (alpha[j*SYM_W +: SYM_W] == cur_sym)) begin
        sym_bad = 1'b1;
      end
    end
  end

  assign check_last = ({1'b0, idx} == (base_length - RADIX_W'(1)));

  // Divider control: first pass from the magnitude, then from each quotient
  assign div_finish   = (div_res.quot == '0) || (cnt == DIG_CNT_W'(MAX_DIGITS - 1));
  assign div_start    = ((state == S_CHECK) && !sym_bad && check_last) ||
                        ((state == S_DIV) && div_res.done && !div_finish);
  assign div_dividend = (state == S_CHECK) ? mag : div_res.quot;

  sirs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (base_length),
    .res      (div_res)
  );

  // Digit read-out, most significant (last pushed) first
  assign slot_free  = !out_valid || out_ready;
  assign cnt_dec    = cnt - DIG_CNT_W'(1);
  assign emit_digit = digits[cnt_dec[DIG_IDX_W-1:0]];
  assign in_ready   = (state == S_IDLE);

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      neg       <= 1'b0;
      idx       <= '0;
      cnt       <= '0;
    end else begin
      // Taken item empties the register; the emit phase refills it itself
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mag <= value_u[DATA_W-1] ? (~value_u + DATA_W'(1)) : value_u;
            neg <= value_u[DATA_W-1];
            idx <= '0;
            cnt <= '0;
            if (len_ok) begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (sym_bad) begin
            state <= S_IDLE;
          end else if (check_last) begin
            state <= S_DIV;
          end else begin
            idx <= idx + DIGIT_W'(1);
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            digits[cnt[DIG_IDX_W-1:0]] <= div_res.rem;
            cnt <= cnt + DIG_CNT_W'(1);
            if (div_finish) begin
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            if (neg) begin
              symbol <= SYM_MINUS;
              last   <= 1'b0;
              neg    <= 1'b0;
            end else begin
              symbol <= alpha[{emit_digit, 3'b000} +: SYM_W];
              last   <= (cnt == DIG_CNT_W'(1));
              cnt    <= cnt_dec;
              if (cnt == DIG_CNT_W'(1)) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Digit store never overflows while dividing
  `SIRS_ASSERT_IMP(a_div_room, state == S_DIV, cnt < DIG_CNT_W'(MAX_DIGITS))
  // Divider only finishes while the sequencer waits for it
  `SIRS_ASSERT_IMP(a_done_in_div, div_res.done, state == S_DIV)
  // A pending non-final character means the value is still being emitted
  `SIRS_ASSERT_IMP(a_mid_value_busy, out_valid && !last, state == S_EMIT)
  // Leaving the emit phase always follows loading the final character
  `SIRS_ASSERT_NEXT(a_emit_exit, state == S_EMIT && slot_free && !neg &&
                    cnt == DIG_CNT_W'(1), out_valid && last && state == S_IDLE)

endmodule

`default_nettype wire
